@@ src/aimn_pkg.sv @@
// Shared types and constants for the inverse affine nearest-neighbor warp block.
package aimn_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_COEF_XX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_XT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YX = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YY = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_YT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_W   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_H   = 3'd7;

  localparam logic [31:0] COEF_UNITY = 32'h0001_0000;
  localparam logic [6:0]  DIM_RESET  = 7'd64;

  localparam logic [7:0]  OUTSIDE_ALPHA = 8'd255;
  localparam logic [23:0] OUTSIDE_COLOR = 24'd0;

  typedef enum logic [1:0] {
    CMD_LOAD_PIXEL = 2'd0,
    CMD_LOAD_ALPHA = 2'd1,
    CMD_MAP        = 2'd2
  } cmd_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [11:0] coord_x;
    logic [11:0] coord_y;
    logic [23:0] pixel_color;
    logic [7:0]  alpha_index;
    logic [7:0]  map_value;
  } in_item_t;

  typedef struct packed {
    logic [23:0] out_color;
    logic [7:0]  out_alpha;
    logic        inside_res;
  } out_item_t;

endpackage

@@ src/affine_inverse_map_nearest.sv @@
// Inverse affine warp with nearest-neighbor sampling from an on-chip source image.
//
// Input items arrive on in_valid / in_stall / in_data. A load-pixel item writes one
// source pixel (color and alpha index), a load-alpha item writes one alpha map entry,
// and a map item transforms a destination coordinate through the Q16.16 coefficients,
// rounds it and samples the source. Only map items produce a result item, which
// leaves on out_valid / out_stall / out_data; other command codes are dropped.
// The configuration port (cfg_we, cfg_index, cfg_data) writes the coefficients and
// the source size. The user must use it only while idle; the block does not enforce it.
// One item is accepted every cycle while in_stall is low. A map result moves stage by
// stage into the output register. The six-stage pipeline is paced by one read of
// the pixel memory and one read of the alpha memory per cycle.
// Synchronous reset clears the pipeline valids and restores the identity transform
// with a 64 by 64 source; both memories hold nothing defined until they are loaded.
// A stalled result holds in the output register while empty stages upstream keep
// filling; in_stall rises only once every stage holds an item.
module affine_inverse_map_nearest #(
  parameter int SRC_DIM_MAX     = 64,
  parameter int DEST_COORD_BITS = 12,
  parameter int ALPHA_MAP_SIZE  = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  aimn_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output aimn_pkg::out_item_t               out_data,
  input  logic                              cfg_we,
  input  logic [aimn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aimn_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aimn_pkg::*;

  localparam int PW    = 33 + DEST_COORD_BITS;
  localparam int SW    = PW + 2;
  localparam int HW    = SW - 16;
  localparam int EW    = $clog2(SRC_DIM_MAX + 1);
  localparam int DB    = (SRC_DIM_MAX > 1) ? $clog2(SRC_DIM_MAX) : 1;
  localparam int DEPTH = SRC_DIM_MAX * SRC_DIM_MAX;
  localparam int AB    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int AW    = $clog2(ALPHA_MAP_SIZE);
  localparam int PXW   = 24 + AW;
  localparam logic signed [SW-1:0] HALF_LSB = SW'(32768);

  logic signed [31:0] coef_xx_r, coef_xy_r, coef_xt_r;
  logic signed [31:0] coef_yx_r, coef_yy_r, coef_yt_r;
  logic [6:0]         src_w_r, src_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_xx_r <= COEF_UNITY;
      coef_xy_r <= '0;
      coef_xt_r <= '0;
      coef_yx_r <= '0;
      coef_yy_r <= COEF_UNITY;
      coef_yt_r <= '0;
      src_w_r   <= DIM_RESET;
      src_h_r   <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COEF_XX: coef_xx_r <= cfg_data;
        REG_COEF_XY: coef_xy_r <= cfg_data;
        REG_COEF_XT: coef_xt_r <= cfg_data;
        REG_COEF_YX: coef_yx_r <= cfg_data;
        REG_COEF_YY: coef_yy_r <= cfg_data;
        REG_COEF_YT: coef_yt_r <= cfg_data;
        REG_SRC_W:   src_w_r   <= cfg_data[6:0];
        REG_SRC_H:   src_h_r   <= cfg_data[6:0];
      endcase
    end
  end

  logic v1_r, v2_r, v3_r, v4_r, v5_r, out_valid_r;
  logic ready1, ready2, ready3, ready4, ready5, ready6;

  assign ready6   = !out_valid_r || !out_stall;
  assign ready5   = !v5_r || ready6;
  assign ready4   = !v4_r || ready5;
  assign ready3   = !v3_r || ready4;
  assign ready2   = !v2_r || ready3;
  assign ready1   = !v1_r || ready2;
  assign in_stall = !ready1;

  in_item_t it1_r, it2_r, it3_r, it4_r;
  logic signed [PW-1:0] p_xx_r, p_xy_r, p_yx_r, p_yy_r;
  logic signed [SW-1:0] tx_r, ty_r;
  logic                 inside4_r, ld_ok4_r;
  logic [AB-1:0]        addr4_r;
  logic [PXW-1:0]       pix_q_r;
  cmd_t                 cmd5_r;
  logic [7:0]           aidx5_r, mval5_r;
  logic                 inside5_r, inside6_r;
  logic [7:0]           alpha_rd_r;
  logic [23:0]          color_q_r;

  logic [PXW-1:0] pix_mem   [DEPTH];
  logic [7:0]     alpha_mem [ALPHA_MAP_SIZE];
  logic [AW-1:0]  mod_lut   [256];

  for (genvar g = 0; g < 256; g++) begin : g_mod_lut
    assign mod_lut[g] = AW'(g % ALPHA_MAP_SIZE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ready1) v1_r <= in_valid;
      if (ready2) v2_r <= v1_r;
      if (ready3) v3_r <= v2_r;
      if (ready4) v4_r <= v3_r;
      if (ready5) v5_r <= v4_r;
      if (ready6) out_valid_r <= v5_r && (cmd5_r == CMD_MAP);
    end
  end

  logic [DEST_COORD_BITS-1:0] dx, dy;
  logic signed [PW-1:0]       dx_s, dy_s;

  assign dx   = DEST_COORD_BITS'(it1_r.coord_x);
  assign dy   = DEST_COORD_BITS'(it1_r.coord_y);
  assign dx_s = PW'($signed({1'b0, dx}));
  assign dy_s = PW'($signed({1'b0, dy}));

  logic signed [SW-1:0] tx_nxt, ty_nxt;

  assign tx_nxt = SW'(p_xx_r) + SW'(p_xy_r) + SW'(coef_xt_r) + HALF_LSB;
  assign ty_nxt = SW'(p_yx_r) + SW'(p_yy_r) + SW'(coef_yt_r) + HALF_LSB;

  logic [EW-1:0] eff_w, eff_h;
  logic [HW-1:0] hx, hy;
  logic          in_x, in_y, ld_ok_nxt, inside_nxt;
  logic [DB-1:0] rx, ry;
  logic [AB-1:0] map_addr, ld_addr, addr_nxt;

  always_comb begin
    eff_w = (32'(src_w_r) > SRC_DIM_MAX) ? EW'(SRC_DIM_MAX) : EW'(src_w_r);
    eff_h = (32'(src_h_r) > SRC_DIM_MAX) ? EW'(SRC_DIM_MAX) : EW'(src_h_r);
    // A biased sum of zero is the exact negative half, which rounds to -1.
    hx   = tx_r[SW-1:16];
    hy   = ty_r[SW-1:16];
    in_x = !tx_r[SW-1] && (tx_r != '0) && (hx < HW'(eff_w));
    in_y = !ty_r[SW-1] && (ty_r != '0) && (hy < HW'(eff_h));
    rx   = hx[DB-1:0];
    ry   = hy[DB-1:0];
    map_addr   = AB'(ry) * AB'(SRC_DIM_MAX) + AB'(rx);
    ld_addr    = AB'(it3_r.coord_y[DB-1:0]) * AB'(SRC_DIM_MAX) + AB'(it3_r.coord_x[DB-1:0]);
    ld_ok_nxt  = (32'(it3_r.coord_x) < SRC_DIM_MAX) && (32'(it3_r.coord_y) < SRC_DIM_MAX);
    inside_nxt = in_x && in_y;
    addr_nxt   = (it3_r.cmd == CMD_MAP) ? map_addr : ld_addr;
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      it1_r <= in_data;
    end
    if (ready2) begin
      it2_r  <= it1_r;
      p_xx_r <= PW'(coef_xx_r) * dx_s;
      p_xy_r <= PW'(coef_xy_r) * dy_s;
      p_yx_r <= PW'(coef_yx_r) * dx_s;
      p_yy_r <= PW'(coef_yy_r) * dy_s;
    end
    if (ready3) begin
      it3_r <= it2_r;
      tx_r  <= tx_nxt;
      ty_r  <= ty_nxt;
    end
    if (ready4) begin
      it4_r     <= it3_r;
      inside4_r <= inside_nxt;
      ld_ok4_r  <= ld_ok_nxt;
      addr4_r   <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && v4_r) begin
      pix_q_r   <= pix_mem[addr4_r];
      cmd5_r    <= it4_r.cmd;
      aidx5_r   <= it4_r.alpha_index;
      mval5_r   <= it4_r.map_value;
      inside5_r <= inside4_r;
      if (it4_r.cmd == CMD_LOAD_PIXEL && ld_ok4_r) begin
        pix_mem[addr4_r] <= {it4_r.pixel_color, mod_lut[it4_r.alpha_index]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready6 && v5_r) begin
      alpha_rd_r <= alpha_mem[pix_q_r[AW-1:0]];
      color_q_r  <= pix_q_r[PXW-1:AW];
      inside6_r  <= inside5_r;
      if (cmd5_r == CMD_LOAD_ALPHA && (32'(aidx5_r) < ALPHA_MAP_SIZE)) begin
        alpha_mem[aidx5_r[AW-1:0]] <= mval5_r;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data.out_color  = inside6_r ? color_q_r : OUTSIDE_COLOR;
  assign out_data.out_alpha  = inside6_r ? alpha_rd_r : OUTSIDE_ALPHA;
  assign out_data.inside_res = inside6_r;

endmodule

@@ src/aimn_checker.sv @@
// Port-level assertions for the inverse affine warp block and their bind.
module aimn_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input aimn_pkg::in_item_t                in_data,
  input logic                              out_valid,
  input logic                              out_stall,
  input aimn_pkg::out_item_t               out_data
);
  import aimn_pkg::*;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input item changed or was withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or was dropped");

  a_accept_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while no result was waiting");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_outside_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.inside_res |->
      out_data.out_alpha == OUTSIDE_ALPHA && out_data.out_color == OUTSIDE_COLOR)
    else $error("outside point carries a source value");

endmodule

bind affine_inverse_map_nearest aimn_checker u_aimn_checker (.*);
